/* hdl/double_ended_queue_top_defines.svh */
// Assertion helpers shared by the queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/deq_pkg.sv */
package deq_pkg;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int IO_DATA_W = 32;
  localparam int FILL_W    = 5;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [IO_DATA_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [IO_DATA_W-1:0] data_out;
    logic [1:0]           status;
    logic [FILL_W-1:0]    fill_count;
  } out_item_t;

endpackage

/* hdl/deq_ram.sv */
module deq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single port: an access either writes or reads
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        store_r[addr] <= wdata;
      end else begin
        rdata_r <= store_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/double_ended_queue_top.sv */
// Bounded double-ended queue of DEPTH elements.
// Input: an item (opcode, data_in) is taken on a rising edge with start high
// and busy low. Opcodes push at back or front, pop from front or back, or
// peek at front or back; codes 6 and 7 do nothing but report.
// Output: every item gives exactly one result, shown on out_item for one
// cycle with out_valid high: data_out (popped or peeked element, else zero),
// status (ok, full, empty) and fill_count after the operation.
// Latency: the result appears in the cycle after the item is accepted.
// Throughput: one item per cycle; busy stays low. The element store is a
// single-port RAM with a registered read; front pointer and count live in
// flops and update at accept, so the next item already sees the new state.
// A read always lands on an entry written at an earlier edge.
// The receiver cannot hold results off; it must take each when shown.
// Reset (synchronous, rst_n low) empties the queue and clears out_valid;
// the store contents are left as they are and are never read before a write.
// Only the low DATA_WIDTH bits (at most 32) of data_in are kept.
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output deq_pkg::out_item_t out_item
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (DATA_WIDTH < IO_DATA_W) ? DATA_WIDTH : IO_DATA_W;
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  logic [FILL_W-1:0] fill_r;
  logic          rd_sel_r;

  logic          accept;
  logic          is_push, is_read, full, empty, op_ok;
  logic [AW:0]   tail_sum, back_sum;
  logic [AW-1:0] tail_ix, back_ix, front_dec, front_inc;
  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [SW-1:0] ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_push = (in_item.opcode == OP_PUSH_BACK) || (in_item.opcode == OP_PUSH_FRONT);
  assign is_read = (in_item.opcode == OP_POP_FRONT) || (in_item.opcode == OP_POP_BACK) ||
                   (in_item.opcode == OP_PEEK_FRONT) || (in_item.opcode == OP_PEEK_BACK);
  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign op_ok = !(is_push && full) && !(is_read && empty);

  // ptr + cnt stays below twice DEPTH, so one conditional subtract wraps it
  assign tail_sum  = {1'b0, ptr_r} + (AW + 1)'(cnt_r);
  assign back_sum  = tail_sum - (AW + 1)'(1);
  assign tail_ix   = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign back_ix   = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
  assign front_dec = (ptr_r == '0) ? LAST_IX : ptr_r - AW'(1);
  assign front_inc = (ptr_r == LAST_IX) ? '0 : ptr_r + AW'(1);

  always_comb begin
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = ptr_r;
    status_nxt = ST_OK;
    if (is_push && full) begin
      status_nxt = ST_FULL;
    end else if (is_read && empty) begin
      status_nxt = ST_EMPTY;
    end else if (accept) begin
      case (in_item.opcode)
        OP_PUSH_BACK: begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = tail_ix;
          cnt_nxt  = cnt_r + CW'(1);
        end
        OP_PUSH_FRONT: begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = front_dec;
          ptr_nxt  = front_dec;
          cnt_nxt  = cnt_r + CW'(1);
        end
        OP_POP_FRONT: begin
          ram_en   = 1'b1;
          ram_addr = ptr_r;
          ptr_nxt  = front_inc;
          cnt_nxt  = cnt_r - CW'(1);
        end
        OP_POP_BACK: begin
          ram_en   = 1'b1;
          ram_addr = back_ix;
          cnt_nxt  = cnt_r - CW'(1);
        end
        OP_PEEK_FRONT: begin
          ram_en   = 1'b1;
          ram_addr = ptr_r;
        end
        OP_PEEK_BACK: begin
          ram_en   = 1'b1;
          ram_addr = back_ix;
        end
        default: begin
          ram_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      rd_sel_r    <= 1'b0;
    end else begin
      if (accept) begin
        ptr_r <= ptr_nxt;
        cnt_r <= cnt_nxt;
      end
      out_valid_r <= accept;
      rd_sel_r    <= accept && op_ok && is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      fill_r   <= FILL_W'(cnt_nxt);
    end
  end

  deq_ram #(
    .DEPTH(DEPTH),
    .WIDTH(SW)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(SW'(in_item.data_in)),
    .rdata(ram_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_item.data_out   = rd_sel_r ? IO_DATA_W'(ram_rdata) : '0;
  assign out_item.status     = status_r;
  assign out_item.fill_count = fill_r;

  `DEQ_ASSERT_NOW(a_cnt_bound, 1'b1, (cnt_r <= FULL_CNT) && (ptr_r <= LAST_IX), "queue state out of range")
  `DEQ_ASSERT_NEXT(a_one_result, 1'b1, out_valid == $past(accept), "result count mismatch")
  `DEQ_ASSERT_NEXT(a_fail_holds, accept && !op_ok, (cnt_r == $past(cnt_r)) && (ptr_r == $past(ptr_r)), "failed op changed state")
  `DEQ_ASSERT_NOW(a_err_zero, out_valid && (out_item.status != ST_OK), !rd_sel_r, "error result carries data")

endmodule
